[hdl/assert_macros.svh]
// Shared assertion macros for the attitude filter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while reset is low.
`define QA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Signal must hold its value in the cycle after cond.
`define QA_ASSERT_STABLE(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> $stable(sig)) \
    else $error("signal changed while stalled");

`endif

[hdl/qapf_pkg.sv]
`default_nettype none
package qapf_pkg;

  typedef struct packed {
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               accel_invalid;
  } out_t;

  localparam int ACC_W = 72;
  localparam int PRD_W = 66;

  localparam logic [1:0] CFG_KP = 2'd0;
  localparam logic [1:0] CFG_KI = 2'd1;
  localparam logic [1:0] CFG_HP = 2'd2;

  localparam logic [23:0] KP_RST = 24'd131072;
  localparam logic [23:0] KI_RST = 24'd16777;
  localparam logic [23:0] HP_RST = 24'd16777;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [ACC_W-1:0] MAX32 = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] MIN32 = -72'sd2147483648;

  // first micro-op of the rate correction / integration segment
  localparam logic [5:0] PC_RATE = 6'd23;

  typedef enum logic [5:0] {
    OP_ONE, OP_AX, OP_AY, OP_AZ,
    OP_Q0, OP_Q1, OP_Q2, OP_Q3,
    OP_AU0, OP_AU1, OP_AU2,
    OP_VX, OP_VY, OP_VZ,
    OP_E0, OP_E1, OP_E2,
    OP_EI0, OP_EI1, OP_EI2,
    OP_G0, OP_G1, OP_G2,
    OP_C, OP_H0, OP_H1, OP_H2,
    OP_N0, OP_N1, OP_N2, OP_N3,
    OP_KP, OP_KI, OP_HP
  } opsel_t;

  typedef enum logic [4:0] {
    D_NONE, D_SQ, D_NSUM,
    D_VX, D_VY, D_VZ,
    D_E0, D_E1, D_E2,
    D_EI0, D_EI1, D_EI2,
    D_C, D_H0, D_H1, D_H2,
    D_N0, D_N1, D_N2, D_N3
  } dst_t;

  typedef enum logic [2:0] {
    SH0, SH2, SH10, SH12, SH26, SH28, SH30
  } sh_t;

  typedef struct packed {
    opsel_t a;
    opsel_t b;
    sh_t    sh;
    logic   neg;
    logic   first;
    logic   dbl;
    dst_t   dst;
    logic   stop;
  } uop_t;

  function automatic uop_t mk(input opsel_t a, input opsel_t b, input sh_t sh,
                              input logic neg, input logic first, input logic dbl,
                              input dst_t dst, input logic stop);
    uop_t u;
    u.a = a; u.b = b; u.sh = sh; u.neg = neg; u.first = first;
    u.dbl = dbl; u.dst = dst; u.stop = stop;
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > MAX32) r = 32'sh7fffffff;
    else if (x < MIN32) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Micro-program: each entry is one multiply-accumulate.
  function automatic uop_t uop_rom(input logic [5:0] pc);
    uop_t u;
    case (pc)
      // accel magnitude squared
      6'd0:  u = mk(OP_AX, OP_AX, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd1:  u = mk(OP_AY, OP_AY, SH0, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd2:  u = mk(OP_AZ, OP_AZ, SH0, 1'b0, 1'b0, 1'b0, D_SQ, 1'b1);
      // predicted gravity
      6'd3:  u = mk(OP_Q1, OP_Q3, SH30, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd4:  u = mk(OP_Q0, OP_Q2, SH30, 1'b1, 1'b0, 1'b1, D_VX, 1'b0);
      6'd5:  u = mk(OP_Q0, OP_Q1, SH30, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd6:  u = mk(OP_Q2, OP_Q3, SH30, 1'b0, 1'b0, 1'b1, D_VY, 1'b0);
      6'd7:  u = mk(OP_Q0, OP_Q0, SH30, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd8:  u = mk(OP_Q1, OP_Q1, SH30, 1'b1, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd9:  u = mk(OP_Q2, OP_Q2, SH30, 1'b1, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd10: u = mk(OP_Q3, OP_Q3, SH30, 1'b0, 1'b0, 1'b0, D_VZ, 1'b0);
      // cross-product error
      6'd11: u = mk(OP_AU1, OP_VZ, SH30, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd12: u = mk(OP_AU2, OP_VY, SH30, 1'b1, 1'b0, 1'b0, D_E0, 1'b0);
      6'd13: u = mk(OP_AU2, OP_VX, SH30, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd14: u = mk(OP_AU0, OP_VZ, SH30, 1'b1, 1'b0, 1'b0, D_E1, 1'b0);
      6'd15: u = mk(OP_AU0, OP_VY, SH30, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd16: u = mk(OP_AU1, OP_VX, SH30, 1'b1, 1'b0, 1'b0, D_E2, 1'b0);
      // integral terms
      6'd17: u = mk(OP_EI0, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd18: u = mk(OP_E0, OP_KI, SH26, 1'b0, 1'b0, 1'b0, D_EI0, 1'b0);
      6'd19: u = mk(OP_EI1, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd20: u = mk(OP_E1, OP_KI, SH26, 1'b0, 1'b0, 1'b0, D_EI1, 1'b0);
      6'd21: u = mk(OP_EI2, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd22: u = mk(OP_E2, OP_KI, SH26, 1'b0, 1'b0, 1'b0, D_EI2, 1'b0);
      // corrected and scaled rates
      6'd23: u = mk(OP_G0, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd24: u = mk(OP_KP, OP_E0, SH28, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd25: u = mk(OP_EI0, OP_ONE, SH10, 1'b0, 1'b0, 1'b0, D_C, 1'b0);
      6'd26: u = mk(OP_C, OP_HP, SH12, 1'b0, 1'b1, 1'b0, D_H0, 1'b0);
      6'd27: u = mk(OP_G1, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd28: u = mk(OP_KP, OP_E1, SH28, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd29: u = mk(OP_EI1, OP_ONE, SH10, 1'b0, 1'b0, 1'b0, D_C, 1'b0);
      6'd30: u = mk(OP_C, OP_HP, SH12, 1'b0, 1'b1, 1'b0, D_H1, 1'b0);
      6'd31: u = mk(OP_G2, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd32: u = mk(OP_KP, OP_E2, SH28, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd33: u = mk(OP_EI2, OP_ONE, SH10, 1'b0, 1'b0, 1'b0, D_C, 1'b0);
      6'd34: u = mk(OP_C, OP_HP, SH12, 1'b0, 1'b1, 1'b0, D_H2, 1'b0);
      // first-order quaternion step
      6'd35: u = mk(OP_Q0, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd36: u = mk(OP_Q1, OP_H0, SH30, 1'b1, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd37: u = mk(OP_Q2, OP_H1, SH30, 1'b1, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd38: u = mk(OP_Q3, OP_H2, SH30, 1'b1, 1'b0, 1'b0, D_N0, 1'b0);
      6'd39: u = mk(OP_Q1, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd40: u = mk(OP_Q0, OP_H0, SH30, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd41: u = mk(OP_Q2, OP_H2, SH30, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd42: u = mk(OP_Q3, OP_H1, SH30, 1'b1, 1'b0, 1'b0, D_N1, 1'b0);
      6'd43: u = mk(OP_Q2, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd44: u = mk(OP_Q0, OP_H1, SH30, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd45: u = mk(OP_Q1, OP_H2, SH30, 1'b1, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd46: u = mk(OP_Q3, OP_H0, SH30, 1'b0, 1'b0, 1'b0, D_N2, 1'b0);
      6'd47: u = mk(OP_Q3, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd48: u = mk(OP_Q0, OP_H2, SH30, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd49: u = mk(OP_Q1, OP_H1, SH30, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd50: u = mk(OP_Q2, OP_H0, SH30, 1'b1, 1'b0, 1'b0, D_N3, 1'b0);
      // squared norm for renormalization
      6'd51: u = mk(OP_N0, OP_N0, SH2, 1'b0, 1'b1, 1'b0, D_NONE, 1'b0);
      6'd52: u = mk(OP_N1, OP_N1, SH2, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd53: u = mk(OP_N2, OP_N2, SH2, 1'b0, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd54: u = mk(OP_N3, OP_N3, SH2, 1'b0, 1'b0, 1'b0, D_NSUM, 1'b1);
      default: u = mk(OP_ONE, OP_ONE, SH0, 1'b0, 1'b1, 1'b0, D_NONE, 1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

[hdl/quaternion_attitude_pi_fusion_top.sv]
// Attitude estimator, IMU only: gyro rates plus accelerometer in, quaternion out.
//
// Input channel (in_valid/in_ready/in_data): one transfer is one sensor sample.
// in_ready is high only while the block is idle; one sample is processed at a time.
// Result channel (out_valid/out_ready/out_data): one transfer per sample, holding
// the renormalized quaternion (Q2.30) and the accel_invalid flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
// is the proportional gain, 1 the integral gain, 2 the half period. Other indexes
// are ignored. Write only while no sample is in flight.
//
// From the input transfer to out_valid a sample runs 55 multiply-accumulates on
// the shared 33x33 multiplier, two 32-step square roots, seven restoring divides
// (three for the accel unit vector, four for renormalizing) and the load of the
// output register. in_ready returns as the output register is loaded.
// A zero accelerometer vector skips the root, three divides and the gravity,
// error and integral terms.
// The finished result sits in an output register; a new sample is taken while it
// waits, and the block only stalls at the end of the next sample if the receiver
// still has not taken the previous one.
// Synchronous reset loads the attitude (1,0,0,0), zero integrals and default gains.
`default_nettype none
module quaternion_attitude_pi_fusion_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  qapf_pkg::in_t       in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output qapf_pkg::out_t      out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [23:0]         cfg_data
);
  import qapf_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAC   = 7'b0000010,
    S_ASQRT = 7'b0000100,
    S_ADIV  = 7'b0001000,
    S_NSQRT = 7'b0010000,
    S_NDIV  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Sample and filter state.
  in_t                in_r;
  logic signed [31:0] att_r [4];
  logic signed [31:0] ei_r  [3];
  logic [23:0]        kp_r, ki_r, hp_r;

  // Working registers of one sample.
  logic signed [31:0] au_r [3];
  logic signed [31:0] e_r  [3];
  logic signed [31:0] h_r  [3];
  logic signed [31:0] qn_r [4];
  logic signed [31:0] vx_r, vy_r, vz_r, c_r;
  logic               inv_r;

  // Multiply-accumulate unit.
  logic [5:0]              pc_r;
  logic                    mph_r;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  uop_t                    uop;
  logic signed [32:0]      opa, opb;
  logic signed [PRD_W-1:0] prd_sh;
  logic signed [ACC_W-1:0] term, acc_base, wbv;
  logic signed [31:0]      wb32;

  // Square root unit, one result bit per cycle.
  logic [63:0] sq_n_r, sq_res_r, sq_bit, sq_trial, sq_n_nxt, sq_res_nxt;
  logic [4:0]  sq_k_r;
  logic        sq_ge;
  logic [31:0] root_r;

  // Restoring divider, one quotient bit per cycle.
  logic [63:0]        dvd_r, dq_r, dq_nxt, dvd_load;
  logic [31:0]        drem_r, drem_nxt;
  logic [32:0]        drem2;
  logic               dge;
  logic [5:0]         dcnt_r;
  logic               dload_r, dneg_r;
  logic [1:0]         del_r;
  logic signed [32:0] dsrc;
  logic [32:0]        dmag;
  logic [30:0]        dclamp;
  logic signed [31:0] dres;

  // Output register.
  out_t out_r;
  logic out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign uop = uop_rom(pc_r);

  function automatic logic signed [32:0] opval(input opsel_t s);
    logic signed [32:0] v;
    case (s)
      OP_ONE: v = 33'sd1;
      OP_AX:  v = {{17{in_r.accel_x[15]}}, in_r.accel_x};
      OP_AY:  v = {{17{in_r.accel_y[15]}}, in_r.accel_y};
      OP_AZ:  v = {{17{in_r.accel_z[15]}}, in_r.accel_z};
      OP_Q0:  v = {att_r[0][31], att_r[0]};
      OP_Q1:  v = {att_r[1][31], att_r[1]};
      OP_Q2:  v = {att_r[2][31], att_r[2]};
      OP_Q3:  v = {att_r[3][31], att_r[3]};
      OP_AU0: v = {au_r[0][31], au_r[0]};
      OP_AU1: v = {au_r[1][31], au_r[1]};
      OP_AU2: v = {au_r[2][31], au_r[2]};
      OP_VX:  v = {vx_r[31], vx_r};
      OP_VY:  v = {vy_r[31], vy_r};
      OP_VZ:  v = {vz_r[31], vz_r};
      OP_E0:  v = {e_r[0][31], e_r[0]};
      OP_E1:  v = {e_r[1][31], e_r[1]};
      OP_E2:  v = {e_r[2][31], e_r[2]};
      OP_EI0: v = {ei_r[0][31], ei_r[0]};
      OP_EI1: v = {ei_r[1][31], ei_r[1]};
      OP_EI2: v = {ei_r[2][31], ei_r[2]};
      OP_G0:  v = {{9{in_r.rate_x[23]}}, in_r.rate_x};
      OP_G1:  v = {{9{in_r.rate_y[23]}}, in_r.rate_y};
      OP_G2:  v = {{9{in_r.rate_z[23]}}, in_r.rate_z};
      OP_C:   v = {c_r[31], c_r};
      OP_H0:  v = {h_r[0][31], h_r[0]};
      OP_H1:  v = {h_r[1][31], h_r[1]};
      OP_H2:  v = {h_r[2][31], h_r[2]};
      OP_N0:  v = {qn_r[0][31], qn_r[0]};
      OP_N1:  v = {qn_r[1][31], qn_r[1]};
      OP_N2:  v = {qn_r[2][31], qn_r[2]};
      OP_N3:  v = {qn_r[3][31], qn_r[3]};
      OP_KP:  v = {9'b0, kp_r};
      OP_KI:  v = {9'b0, ki_r};
      OP_HP:  v = {9'b0, hp_r};
      default: v = '0;
    endcase
    return v;
  endfunction

  // MAC datapath: floor shift of the registered product, then add or subtract.
  always_comb begin
    opa = opval(uop.a);
    opb = opval(uop.b);
    case (uop.sh)
      SH0:  prd_sh = prod_r;
      SH2:  prd_sh = prod_r >>> 2;
      SH10: prd_sh = prod_r >>> 10;
      SH12: prd_sh = prod_r >>> 12;
      SH26: prd_sh = prod_r >>> 26;
      SH28: prd_sh = prod_r >>> 28;
      SH30: prd_sh = prod_r >>> 30;
      default: prd_sh = prod_r;
    endcase
    term     = {{(ACC_W-PRD_W){prd_sh[PRD_W-1]}}, prd_sh};
    acc_base = uop.first ? '0 : acc_r;
    acc_nxt  = uop.neg ? (acc_base - term) : (acc_base + term);
    wbv      = uop.dbl ? (acc_nxt <<< 1) : acc_nxt;
    wb32     = sat32(wbv);
  end

  // Square root step.
  always_comb begin
    sq_bit     = 64'd1 << {sq_k_r, 1'b0};
    sq_trial   = sq_res_r + sq_bit;
    sq_ge      = (sq_n_r >= sq_trial);
    sq_n_nxt   = sq_ge ? (sq_n_r - sq_trial) : sq_n_r;
    sq_res_nxt = sq_ge ? ((sq_res_r >> 1) + sq_bit) : (sq_res_r >> 1);
  end

  // Divide step, operand select and result clamp.
  always_comb begin
    drem2    = {drem_r, dvd_r[63]};
    dge      = (drem2 >= {1'b0, root_r});
    drem_nxt = dge ? 32'(drem2 - {1'b0, root_r}) : drem2[31:0];
    dq_nxt   = {dq_r[62:0], dge};
    if (state_r == S_ADIV) begin
      case (del_r)
        2'd0:    dsrc = {{17{in_r.accel_x[15]}}, in_r.accel_x};
        2'd1:    dsrc = {{17{in_r.accel_y[15]}}, in_r.accel_y};
        default: dsrc = {{17{in_r.accel_z[15]}}, in_r.accel_z};
      endcase
    end else begin
      dsrc = {qn_r[del_r][31], qn_r[del_r]};
    end
    dmag     = dsrc[32] ? 33'(-dsrc) : dsrc;
    dvd_load = (state_r == S_ADIV) ? (64'(dmag) << 46) : (64'(dmag) << 29);
    dclamp   = (dq_nxt > 64'd1073741824) ? 31'd1073741824 : dq_nxt[30:0];
    dres     = dneg_r ? -$signed({1'b0, dclamp}) : $signed({1'b0, dclamp});
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MAC;
      S_MAC: begin
        if (mph_r && uop.stop) begin
          if (uop.dst == D_SQ) begin
            state_nxt = (acc_nxt[31:0] == 32'd0) ? S_MAC : S_ASQRT;
          end else begin
            state_nxt = (acc_nxt == '0) ? S_DONE : S_NSQRT;
          end
        end
      end
      S_ASQRT: if (sq_k_r == 5'd0) state_nxt = S_ADIV;
      S_NSQRT: if (sq_k_r == 5'd0) state_nxt = S_NDIV;
      S_ADIV:  if (!dload_r && dcnt_r == 6'd63 && del_r == 2'd2) state_nxt = S_MAC;
      S_NDIV:  if (!dload_r && dcnt_r == 6'd63 && del_r == 2'd3) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mph_r       <= 1'b0;
      att_r[0]    <= ONE_Q30;
      att_r[1]    <= '0;
      att_r[2]    <= '0;
      att_r[3]    <= '0;
      ei_r[0]     <= '0;
      ei_r[1]     <= '0;
      ei_r[2]     <= '0;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      hp_r        <= HP_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_KP:  kp_r <= cfg_data;
          CFG_KI:  ki_r <= cfg_data;
          CFG_HP:  hp_r <= cfg_data;
          default: ;
        endcase
      end

      // in S_DONE the output register is reloaded below
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r  <= in_data;
            pc_r  <= '0;
            mph_r <= 1'b0;
            inv_r <= 1'b0;
            e_r[0] <= '0;
            e_r[1] <= '0;
            e_r[2] <= '0;
          end
        end

        S_MAC: begin
          if (!mph_r) begin
            prod_r <= opa * opb;
            mph_r  <= 1'b1;
          end else begin
            mph_r <= 1'b0;
            acc_r <= acc_nxt;
            // zero accel: no correction, go straight to rate integration
            pc_r  <= (uop.dst == D_SQ && acc_nxt[31:0] == 32'd0) ? PC_RATE :
                     pc_r + 6'd1;
            case (uop.dst)
              D_VX:  vx_r    <= wb32;
              D_VY:  vy_r    <= wb32;
              D_VZ:  vz_r    <= wb32;
              D_E0:  e_r[0]  <= wb32;
              D_E1:  e_r[1]  <= wb32;
              D_E2:  e_r[2]  <= wb32;
              D_EI0: ei_r[0] <= wb32;
              D_EI1: ei_r[1] <= wb32;
              D_EI2: ei_r[2] <= wb32;
              D_C:   c_r     <= wb32;
              D_H0:  h_r[0]  <= wb32;
              D_H1:  h_r[1]  <= wb32;
              D_H2:  h_r[2]  <= wb32;
              D_N0:  qn_r[0] <= wb32;
              D_N1:  qn_r[1] <= wb32;
              D_N2:  qn_r[2] <= wb32;
              D_N3:  qn_r[3] <= wb32;
              D_SQ: begin
                if (acc_nxt[31:0] == 32'd0) begin
                  inv_r <= 1'b1;
                end else begin
                  sq_n_r   <= {acc_nxt[31:0], 32'd0};
                  sq_res_r <= '0;
                  sq_k_r   <= 5'd31;
                end
              end
              D_NSUM: begin
                if (acc_nxt == '0) begin
                  // degenerate quaternion: restart from identity
                  att_r[0] <= ONE_Q30;
                  att_r[1] <= '0;
                  att_r[2] <= '0;
                  att_r[3] <= '0;
                end else begin
                  sq_n_r   <= acc_nxt[63:0];
                  sq_res_r <= '0;
                  sq_k_r   <= 5'd31;
                end
              end
              default: ;
            endcase
          end
        end

        S_ASQRT, S_NSQRT: begin
          sq_n_r   <= sq_n_nxt;
          sq_res_r <= sq_res_nxt;
          sq_k_r   <= sq_k_r - 5'd1;
          if (sq_k_r == 5'd0) begin
            root_r  <= sq_res_nxt[31:0];
            del_r   <= '0;
            dload_r <= 1'b1;
          end
        end

        S_ADIV, S_NDIV: begin
          if (dload_r) begin
            dvd_r   <= dvd_load;
            drem_r  <= '0;
            dq_r    <= '0;
            dcnt_r  <= '0;
            dneg_r  <= dsrc[32];
            dload_r <= 1'b0;
          end else begin
            dvd_r  <= dvd_r << 1;
            drem_r <= drem_nxt;
            dq_r   <= dq_nxt;
            dcnt_r <= dcnt_r + 6'd1;
            if (dcnt_r == 6'd63) begin
              if (state_r == S_ADIV) au_r[del_r] <= dres;
              else att_r[del_r] <= dres;
              del_r   <= del_r + 2'd1;
              dload_r <= 1'b1;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.quat_w        <= att_r[0];
            out_r.quat_x        <= att_r[1];
            out_r.quat_y        <= att_r[2];
            out_r.quat_z        <= att_r[3];
            out_r.accel_invalid <= inv_r;
            out_valid_r         <= 1'b1;
          end
        end

        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/qapf_chk.sv]
`default_nettype none
`include "assert_macros.svh"
module qapf_chk (
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input qapf_pkg::out_t out_data
);
  import qapf_pkg::*;

  `QA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `QA_ASSERT_STABLE(a_out_stable, clk, rst_n, out_valid && !out_ready, out_data)
  // one sample at a time: the input closes right after a transfer
  `QA_ASSERT(a_in_busy, clk, rst_n, in_valid && in_ready |=> !in_ready)
  // renormalized w and x components never exceed one in magnitude
  `QA_ASSERT(a_norm, clk, rst_n, out_valid |-> (out_data.quat_w <= ONE_Q30) && (out_data.quat_w >= -ONE_Q30) && (out_data.quat_x <= ONE_Q30) && (out_data.quat_x >= -ONE_Q30))

endmodule

bind quaternion_attitude_pi_fusion_top qapf_chk u_qapf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/qapf_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
// Watches all three channels, predicts each result and compares on transfer.
module qapf_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  qapf_pkg::in_t      in_data,
  input  wire                out_valid,
  input  wire                out_ready,
  input  qapf_pkg::out_t     out_data,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [23:0]        cfg_data,
  output int                 errors,
  output int                 results_seen,
  output int                 pending
);
  import qapf_pkg::*;

  localparam longint Q30 = 64'sd1073741824;
  localparam longint HI32 = 64'sd2147483647;
  localparam longint LO32 = -64'sd2147483648;

  longint      att [4];
  longint      integ [3];
  logic [23:0] kp, ki, hp;
  out_t        quat_q [$];

  function automatic longint clip32(input longint x);
    if (x > HI32) return HI32;
    if (x < LO32) return LO32;
    return x;
  endfunction

  function automatic longint mul_fl(input longint a, input longint b, input int sh);
    return (a * b) >>> sh;
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // sign(v) * min(|v| << sh / den, 1.0)
  function automatic longint to_unit(input longint v, input int sh,
                                     input longint unsigned den);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = (mag << sh) / den;
    if (r > 64'd1073741824) r = 64'd1073741824;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // Advances the stored attitude by one sample and returns the result.
  function automatic out_t attitude_step(input in_t d);
    longint g [3], a [3], e [3], h [3], q [4], nq [4];
    longint q0, q1, q2, q3, vx, vy, vz, c;
    longint unsigned s, n2, r;
    out_t o;
    q0 = att[0]; q1 = att[1]; q2 = att[2]; q3 = att[3];
    g[0] = d.rate_x; g[1] = d.rate_y; g[2] = d.rate_z;
    a[0] = d.accel_x; a[1] = d.accel_y; a[2] = d.accel_z;
    e[0] = 0; e[1] = 0; e[2] = 0;
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    o.accel_invalid = (s == 0);
    if (s != 0) begin
      r = root64(s << 32);
      for (int i = 0; i < 3; i++) a[i] = to_unit(a[i], 46, r);
      vx = clip32(2 * (mul_fl(q1, q3, 30) - mul_fl(q0, q2, 30)));
      vy = clip32(2 * (mul_fl(q0, q1, 30) + mul_fl(q2, q3, 30)));
      vz = clip32(mul_fl(q0, q0, 30) - mul_fl(q1, q1, 30) - mul_fl(q2, q2, 30)
                  + mul_fl(q3, q3, 30));
      e[0] = clip32(mul_fl(a[1], vz, 30) - mul_fl(a[2], vy, 30));
      e[1] = clip32(mul_fl(a[2], vx, 30) - mul_fl(a[0], vz, 30));
      e[2] = clip32(mul_fl(a[0], vy, 30) - mul_fl(a[1], vx, 30));
      for (int i = 0; i < 3; i++)
        integ[i] = clip32(integ[i] + mul_fl(e[i], longint'(ki), 26));
    end
    for (int i = 0; i < 3; i++) begin
      c = clip32(g[i] + mul_fl(longint'(kp), e[i], 28) + (integ[i] >>> 10));
      h[i] = clip32(mul_fl(c, longint'(hp), 12));
    end
    q[0] = clip32(q0 - mul_fl(q1, h[0], 30) - mul_fl(q2, h[1], 30) - mul_fl(q3, h[2], 30));
    q[1] = clip32(q1 + mul_fl(q0, h[0], 30) + mul_fl(q2, h[2], 30) - mul_fl(q3, h[1], 30));
    q[2] = clip32(q2 + mul_fl(q0, h[1], 30) - mul_fl(q1, h[2], 30) + mul_fl(q3, h[0], 30));
    q[3] = clip32(q3 + mul_fl(q0, h[2], 30) + mul_fl(q1, h[1], 30) - mul_fl(q2, h[0], 30));
    n2 = 0;
    for (int i = 0; i < 4; i++) n2 = n2 + (longint'(q[i] * q[i]) >> 2);
    if (n2 == 0) begin
      nq[0] = Q30; nq[1] = 0; nq[2] = 0; nq[3] = 0;
    end else begin
      r = root64(n2);
      for (int i = 0; i < 4; i++) nq[i] = to_unit(q[i], 29, r);
    end
    for (int i = 0; i < 4; i++) att[i] = nq[i];
    o.quat_w = nq[0][31:0];
    o.quat_x = nq[1][31:0];
    o.quat_y = nq[2][31:0];
    o.quat_z = nq[3][31:0];
    return o;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      att[0] = Q30; att[1] = 0; att[2] = 0; att[3] = 0;
      integ[0] = 0; integ[1] = 0; integ[2] = 0;
      kp = KP_RST; ki = KI_RST; hp = HP_RST;
      quat_q.delete();
      errors <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KP: kp = cfg_data;
          CFG_KI: ki = cfg_data;
          CFG_HP: hp = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (quat_q.size() == 0) begin
          $error("result with no sample outstanding");
          errors <= errors + 1;
        end else begin
          want = quat_q.pop_front();
          if (want.quat_w !== out_data.quat_w)
            $error("quat_w expected %0d got %0d", want.quat_w, out_data.quat_w);
          if (want.quat_x !== out_data.quat_x)
            $error("quat_x expected %0d got %0d", want.quat_x, out_data.quat_x);
          if (want.quat_y !== out_data.quat_y)
            $error("quat_y expected %0d got %0d", want.quat_y, out_data.quat_y);
          if (want.quat_z !== out_data.quat_z)
            $error("quat_z expected %0d got %0d", want.quat_z, out_data.quat_z);
          if (want.accel_invalid !== out_data.accel_invalid)
            $error("accel_invalid expected %0d got %0d",
                   want.accel_invalid, out_data.accel_invalid);
          if (want !== out_data) errors <= errors + 1;
        end
      end
      if (in_valid && in_ready) quat_q.push_back(attitude_step(in_data));
      pending <= quat_q.size();
    end
  end
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import qapf_pkg::*;

  // Index outside the register map; the block must ignore it.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SEG_ITEMS = 400;
  // Watchdog bound for a run of 1600+ samples.
  localparam int CYCLE_LIMIT = 8000000;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  [1:0] cfg_index;
  logic  [23:0] cfg_data;

  int errors, results_seen, pending;
  int sent, zero_accel_cnt;
  int cycles = 0;
  int tx_idle_pct, rx_idle_pct;

  quaternion_attitude_pi_fusion_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  qapf_checker i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .results_seen(results_seen), .pending(pending)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One sample transfer; the sender may idle first.
  task automatic send_sample(input in_t d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    if (d.accel_x == 0 && d.accel_y == 0 && d.accel_z == 0)
      zero_accel_cnt++;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen != sent);
    repeat (50) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t mk_sample(input int rx, input int ry, input int rz,
                                    input int ax, input int ay, input int az);
    in_t d;
    d.rate_x = rx[23:0]; d.rate_y = ry[23:0]; d.rate_z = rz[23:0];
    d.accel_x = ax[15:0]; d.accel_y = ay[15:0]; d.accel_z = az[15:0];
    return d;
  endfunction

  function automatic int rand_rate;
    int v;
    case ($urandom_range(3))
      0: v = $signed($urandom() << 8) >>> 8;  // full 24-bit range
      1: v = $urandom_range(0, 1 << 21) - (1 << 20);
      default: v = $urandom_range(0, 1 << 18) - (1 << 17);  // within +-0.5 rad/s
    endcase
    return v;
  endfunction

  function automatic int rand_accel(input int bias);
    int v;
    if ($urandom_range(3) == 0) v = $signed($urandom() << 16) >>> 16;
    else v = bias + $urandom_range(0, 8192) - 4096;
    return v;
  endfunction

  task automatic random_sample;
    if ($urandom_range(99) < 4)
      send_sample(mk_sample(rand_rate(), rand_rate(), rand_rate(), 0, 0, 0));
    else
      send_sample(mk_sample(rand_rate(), rand_rate(), rand_rate(),
                            rand_accel(0), rand_accel(0), rand_accel(16384)));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_KP;
    cfg_data  <= '0;
    sent = 0;
    zero_accel_cnt = 0;
    tx_idle_pct = 7;
    rx_idle_pct = 83;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, level attitude, zero accel vector, saturating rates.
    send_sample(mk_sample(0, 0, 0, 0, 0, 16384));
    send_sample(mk_sample(0, 0, 0, 0, 0, 0));
    send_sample(mk_sample(8388607, 8388607, 8388607, 32767, 32767, 32767));
    send_sample(mk_sample(-8388608, -8388608, -8388608, -32768, -32768, -32768));
    send_sample(mk_sample(8388607, -8388608, 0, 0, 0, 0));
    send_sample(mk_sample(0, 0, 0, 1, 0, 0));
    send_sample(mk_sample(0, 0, 0, 0, -1, 0));
    send_sample(mk_sample(0, 0, 0, 0, 0, -1));
    send_sample(mk_sample(1, -1, 1, 32767, -32768, 0));
    send_sample(mk_sample(0, 0, 0, 16384, 0, 0));
    send_sample(mk_sample(262144, 0, 0, 0, 16384, 0));
    send_sample(mk_sample(0, 0, -262144, -16384, 0, 0));
    drain();

    // Extreme gains and period: saturation paths everywhere.
    cfg_write(CFG_KP, 24'hFFFFFF);
    cfg_write(CFG_KI, 24'hFFFFFF);
    cfg_write(CFG_HP, 24'hFFFFFF);
    send_sample(mk_sample(8388607, 8388607, 8388607, 0, 0, 0));
    send_sample(mk_sample(-8388608, 8388607, -8388608, 32767, -32768, 32767));
    send_sample(mk_sample(0, 0, 0, 0, 32767, 0));
    send_sample(mk_sample(8388607, 0, -8388608, -32768, 0, 0));
    send_sample(mk_sample(0, 0, 0, 0, 0, 0));
    drain();
    cfg_write(CFG_KP, 24'h0);
    cfg_write(CFG_KI, 24'h0);
    cfg_write(CFG_HP, 24'h0);
    cfg_write(CFG_SPARE, 24'hFFFFFF);
    send_sample(mk_sample(8388607, -8388608, 8388607, 32767, 32767, -32768));
    send_sample(mk_sample(0, 0, 0, 0, 0, 0));
    drain();

    // Segment 1: defaults restored, slow receiver.
    cfg_write(CFG_KP, KP_RST);
    cfg_write(CFG_KI, KI_RST);
    cfg_write(CFG_HP, HP_RST);
    repeat (SEG_ITEMS) random_sample();
    drain();

    // Segment 2: slow sender, strong gains.
    tx_idle_pct = 83;
    rx_idle_pct = 7;
    cfg_write(CFG_KP, 24'hFFFFFF);
    cfg_write(CFG_KI, 24'hFFFFFF);
    cfg_write(CFG_HP, 24'($urandom_range(1 << 20)));
    repeat (SEG_ITEMS) random_sample();
    drain();

    // Segments 3 and 4: no idling, random gains; half period zero in 3, random in 4.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int seg = 0; seg < 2; seg++) begin
      cfg_write(CFG_KP, 24'($urandom()));
      cfg_write(CFG_KI, 24'($urandom()));
      cfg_write(CFG_HP, (seg == 0) ? 24'h0 : 24'(($urandom() >> 8)));
      repeat (SEG_ITEMS) random_sample();
      drain();
    end

    repeat (700) @(posedge clk);
    $display("Covered %0d samples (%0d with zero accel) over default, extreme and random gains,",
             sent, zero_accel_cnt);
    $display("with sender and receiver idling in turn; %0d results checked.", results_seen);
    if (errors == 0 && pending == 0 && results_seen == sent) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
